/* hdl/cds_pkg.sv */
// Shared constants and types for the CPU debug stop unit.
package cds_pkg;

    // Item modes
    localparam logic [3:0] MODE_FETCH     = 4'd0;
    localparam logic [3:0] MODE_BP_ADD    = 4'd1;
    localparam logic [3:0] MODE_BP_REMOVE = 4'd2;
    localparam logic [3:0] MODE_BP_CLEAR  = 4'd3;
    localparam logic [3:0] MODE_BP_QUERY  = 4'd4;
    localparam logic [3:0] MODE_PAUSE     = 4'd5;
    localparam logic [3:0] MODE_BREAK     = 4'd6;
    localparam logic [3:0] MODE_ENTRY     = 4'd7;
    localparam logic [3:0] MODE_DATA      = 4'd8;
    localparam logic [3:0] MODE_CONTINUE  = 4'd9;
    localparam logic [3:0] MODE_STEP      = 4'd10;
    localparam logic [3:0] MODE_NOTE      = 4'd11;

    // Stop causes
    localparam logic [2:0] CAUSE_PAUSE = 3'd0;
    localparam logic [2:0] CAUSE_DATA  = 3'd1;
    localparam logic [2:0] CAUSE_ENTRY = 3'd2;
    localparam logic [2:0] CAUSE_STEP  = 3'd3;
    localparam logic [2:0] CAUSE_BP    = 3'd4;

    // Step kinds
    localparam logic [2:0] STEP_NONE  = 3'd0;
    localparam logic [2:0] STEP_INSTR = 3'd1;
    localparam logic [2:0] STEP_OVER  = 3'd2;
    localparam logic [2:0] STEP_INTO  = 3'd3;
    localparam logic [2:0] STEP_OUT   = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_TABLE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_FILTER = 1'd1;

    // Bitmap row layout: breakpoint flags are stored 32 to a memory row
    localparam int unsigned ROW_W    = 32;
    localparam int unsigned ROW_BITS = 5;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_CLEAR = 3'b100
    } t_state;

endpackage

/* hdl/cds_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module cds_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/cpu_debug_stop_unit.sv */
// Debug stop unit: breakpoint bitmap, stop requests and step control for an 8-bit CPU.
// Each request is handled in order: in the accept cycle the bitmap row holding the
// request's address is read from the RAM; in the execute state, once the result
// output is not stalled, the stop decision is made, the row is written back for a
// breakpoint add or remove, and the result is registered. The bitmap RAM's registered
// read data sets this split. A new request is taken as soon as the unit is back in
// idle, even while the previous result still waits at the output. After reset, and
// after every clear-all request, the unit sweeps the bitmap one row of 32 flags per
// cycle, BP_ENTRIES/32 rows (2048 at the default size), and holds o_in_stall high
// meanwhile; configuration writes are taken at any time. BP_ENTRIES must be a power
// of two; the bitmap index is the low address bits.
module cpu_debug_stop_unit #(
    parameter int unsigned BP_ENTRIES = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                           i_cfg_data,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [3:0]                     i_mode,
    input  logic [15:0]                    i_address,
    input  logic [7:0]                     i_stack_ptr,
    input  logic [2:0]                     i_step_kind,
    input  logic [15:0]                    i_line_tag,
    input  logic [7:0]                     i_file_tag,
    input  logic                           i_filter_pass,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_stop_now,
    output logic                           o_is_stopped,
    output logic [2:0]                     o_reason_out,
    output logic [15:0]                    o_stop_pc_out,
    output logic                           o_breakpoint_present,
    output logic [15:0]                    o_watch_address
);

    import cds_pkg::*;

    localparam int unsigned IDX_W  = $clog2(BP_ENTRIES);
    localparam int unsigned ROWS   = BP_ENTRIES / ROW_W;
    localparam int unsigned ROW_AW = $clog2(ROWS);

    // sequencer
    t_state r_state, n_state;
    logic [ROW_AW-1:0] r_clr_row;
    logic              w_accept;
    logic              w_go;

    // configuration
    logic r_line_table;
    logic r_break_filter;

    // latched request
    logic [3:0]  r_mode;
    logic [15:0] r_addr;
    logic [7:0]  r_sp;
    logic [2:0]  r_kind;
    logic [15:0] r_line;
    logic [7:0]  r_file;
    logic        r_pass;

    // debug state
    logic        r_stopped,  n_stopped;
    logic [2:0]  r_cause,    n_cause;
    logic [15:0] r_stop_pc,  n_stop_pc;
    logic [7:0]  r_stop_sp,  n_stop_sp;
    logic [7:0]  r_cur_sp,   n_cur_sp;
    logic [2:0]  r_step_mode, n_step_mode;
    logic [7:0]  r_step_sp,  n_step_sp;
    logic [15:0] r_step_line, n_step_line;
    logic [7:0]  r_step_file, n_step_file;
    logic        r_pause_pend, n_pause_pend;
    logic        r_break_pend, n_break_pend;
    logic        r_entry_pend, n_entry_pend;
    logic        r_data_pend,  n_data_pend;
    logic [15:0] r_data_addr,  n_data_addr;

    // result register
    logic        r_out_valid;
    logic        r_stop_now, n_stop_now;
    logic        r_bp_out,   n_bp_out;

    // bitmap RAM
    logic              w_we;
    logic [ROW_AW-1:0] w_waddr;
    logic [ROW_W-1:0]  w_wdata;
    logic [ROW_W-1:0]  w_rdata;
    logic [ROW_AW-1:0] w_raddr;
    logic [ROW_AW-1:0] w_req_row;
    logic [ROW_BITS-1:0] w_req_bit;
    logic              w_bp_bit;
    logic              w_step_done;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_go     = (r_state == ST_EXEC) && !(r_out_valid && i_out_stall);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_raddr   = i_address[IDX_W-1:ROW_BITS];
    assign w_req_row = r_addr[IDX_W-1:ROW_BITS];
    assign w_req_bit = r_addr[ROW_BITS-1:0];
    assign w_bp_bit  = w_rdata[w_req_bit];

    cds_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_bp_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // bitmap write: clearing sweep or read-modify-write of one flag
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_req_row;
        w_wdata = w_rdata;
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_row;
            w_wdata = '0;
        end else if (w_go && (r_mode == MODE_BP_ADD || r_mode == MODE_BP_REMOVE)) begin
            w_we = 1'b1;
            w_wdata[w_req_bit] = (r_mode == MODE_BP_ADD);
        end
    end

    // step completion test for the current fetch
    always_comb begin
        w_step_done = 1'b1;
        if (r_step_mode == STEP_INSTR) begin
            w_step_done = 1'b1;
        end else if (r_step_mode == STEP_OUT) begin
            w_step_done = (r_sp > r_step_sp);
        end else if (!r_line_table || r_step_line == '0) begin
            w_step_done = (r_step_mode == STEP_OVER) ? (r_sp >= r_step_sp) : 1'b1;
        end else if (r_step_mode == STEP_OVER && r_sp < r_step_sp) begin
            w_step_done = 1'b0;
        end else begin
            w_step_done = (r_line != '0) &&
                          ((r_line != r_step_line) || (r_file != r_step_file));
        end
    end

    // request execution
    always_comb begin
        logic       v_stop;
        logic [2:0] v_cause;
        v_stop       = 1'b0;
        v_cause      = CAUSE_PAUSE;
        n_stopped    = r_stopped;
        n_cause      = r_cause;
        n_stop_pc    = r_stop_pc;
        n_stop_sp    = r_stop_sp;
        n_cur_sp     = r_cur_sp;
        n_step_mode  = r_step_mode;
        n_step_sp    = r_step_sp;
        n_step_line  = r_step_line;
        n_step_file  = r_step_file;
        n_pause_pend = r_pause_pend;
        n_break_pend = r_break_pend;
        n_entry_pend = r_entry_pend;
        n_data_pend  = r_data_pend;
        n_data_addr  = r_data_addr;
        n_bp_out     = w_bp_bit;

        case (r_mode)
            MODE_FETCH: begin
                n_cur_sp = r_sp;
                if (r_pause_pend) begin
                    v_stop  = 1'b1;
                    v_cause = CAUSE_PAUSE;
                end else if (r_data_pend) begin
                    v_stop      = 1'b1;
                    v_cause     = CAUSE_DATA;
                    n_data_pend = 1'b0;
                end else if (r_entry_pend) begin
                    v_stop       = 1'b1;
                    v_cause      = CAUSE_ENTRY;
                    n_entry_pend = 1'b0;
                end else if (r_step_mode != STEP_NONE && w_step_done) begin
                    v_stop  = 1'b1;
                    v_cause = CAUSE_STEP;
                end else if (r_break_pend) begin
                    v_stop  = 1'b1;
                    v_cause = CAUSE_BP;
                end else if (w_bp_bit && (!r_break_filter || r_pass)) begin
                    v_stop  = 1'b1;
                    v_cause = CAUSE_BP;
                end
                if (v_stop) begin
                    n_stopped    = 1'b1;
                    n_cause      = v_cause;
                    n_stop_pc    = r_addr;
                    n_stop_sp    = r_sp;
                    n_step_mode  = STEP_NONE;
                    n_pause_pend = 1'b0;
                    n_break_pend = 1'b0;
                end
            end
            MODE_BP_ADD:    n_bp_out = 1'b1;
            MODE_BP_REMOVE: n_bp_out = 1'b0;
            MODE_BP_CLEAR:  n_bp_out = 1'b0;
            MODE_PAUSE:     n_pause_pend = 1'b1;
            MODE_BREAK:     n_break_pend = 1'b1;
            MODE_ENTRY:     n_entry_pend = 1'b1;
            MODE_DATA: begin
                n_data_pend = 1'b1;
                n_data_addr = r_addr;
            end
            MODE_CONTINUE: begin
                n_step_mode = STEP_NONE;
                n_stopped   = 1'b0;
            end
            MODE_STEP: begin
                if (r_stopped) begin
                    n_step_mode = (r_kind <= STEP_OUT) ? r_kind : STEP_NONE;
                    n_step_sp   = r_stop_sp;
                    n_step_line = r_line_table ? r_line : '0;
                    n_step_file = r_line_table ? r_file : '0;
                    n_stopped   = 1'b0;
                end
            end
            MODE_NOTE: begin
                n_stopped   = 1'b1;
                n_cause     = CAUSE_PAUSE;
                n_stop_pc   = r_addr;
                n_stop_sp   = r_cur_sp;
                n_step_mode = STEP_NONE;
            end
            default: ;
        endcase
        n_stop_now = v_stop;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_EXEC;
            ST_EXEC: begin
                if (w_go) begin
                    n_state = (r_mode == MODE_BP_CLEAR) ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR: if (r_clr_row == ROW_AW'(ROWS - 1)) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // control and debug state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_row      <= '0;
            r_line_table   <= 1'b0;
            r_break_filter <= 1'b0;
            r_out_valid    <= 1'b0;
            r_stopped      <= 1'b0;
            r_cause        <= CAUSE_PAUSE;
            r_stop_pc      <= '0;
            r_stop_sp      <= '0;
            r_cur_sp       <= '0;
            r_step_mode    <= STEP_NONE;
            r_step_sp      <= '0;
            r_step_line    <= '0;
            r_step_file    <= '0;
            r_pause_pend   <= 1'b0;
            r_break_pend   <= 1'b0;
            r_entry_pend   <= 1'b0;
            r_data_pend    <= 1'b0;
            r_data_addr    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end else begin
                r_clr_row <= '0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINE_TABLE:   r_line_table   <= i_cfg_data;
                    CFG_BREAK_FILTER: r_break_filter <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_go) begin
                r_stopped    <= n_stopped;
                r_cause      <= n_cause;
                r_stop_pc    <= n_stop_pc;
                r_stop_sp    <= n_stop_sp;
                r_cur_sp     <= n_cur_sp;
                r_step_mode  <= n_step_mode;
                r_step_sp    <= n_step_sp;
                r_step_line  <= n_step_line;
                r_step_file  <= n_step_file;
                r_pause_pend <= n_pause_pend;
                r_break_pend <= n_break_pend;
                r_entry_pend <= n_entry_pend;
                r_data_pend  <= n_data_pend;
                r_data_addr  <= n_data_addr;
            end
        end
    end

    // request latch and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_addr <= i_address;
            r_sp   <= i_stack_ptr;
            r_kind <= i_step_kind;
            r_line <= i_line_tag;
            r_file <= i_file_tag;
            r_pass <= i_filter_pass;
        end
        if (w_go) begin
            r_stop_now <= n_stop_now;
            r_bp_out   <= n_bp_out;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_stop_now           = r_stop_now;
    assign o_is_stopped         = r_stopped;
    assign o_reason_out         = r_cause;
    assign o_stop_pc_out        = r_stop_pc;
    assign o_breakpoint_present = r_bp_out;
    assign o_watch_address      = r_data_addr;

    // a stop reported in a result leaves the unit stopped
    a_stop_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stop_now) |-> o_is_stopped)
        else $error("stop reported without stopped flag");

    // an accepted request puts the sequencer in the execute state in the following cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted request not executed");

    // the bitmap is written only by the sweep or a completing request
    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == ST_CLEAR) || w_go))
        else $error("bitmap write outside sweep or execution");

    // no result is produced while the bitmap is being cleared
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> !$rose(o_out_valid))
        else $error("result produced during bitmap clear");

endmodule
